// ----- hw/rtl/iee_pkg.sv -----
package iee_pkg;

   localparam int StackDepth = 16;
   localparam int ValueWidth = 32;
   localparam int PtrWidth   = $clog2(StackDepth);
   localparam int CntWidth   = $clog2(StackDepth + 1);

   // operator codes as kept on the operator stack
   typedef enum logic [2:0] {
      OP_OPEN = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DIV0   = 2'd1;
   localparam logic [1:0] ST_SYMBOL = 2'd2;
   localparam logic [1:0] ST_MALFORM = 2'd3;

   localparam logic [7:0] CH_ADD   = 8'h2B;
   localparam logic [7:0] CH_SUB   = 8'h2D;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_POP_OP,
      S_POP_B,
      S_POP_A,
      S_EXEC,
      S_DIV_RUN,
      S_PUSH_R,
      S_APPLY,
      S_FINISH,
      S_READ_RES,
      S_OUTPUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic take_item;   // latch symbol and last
      logic rd_op;       // read top operator
      logic rd_val;      // read top value
      logic lat_b;       // latch value read data into b
      logic lat_a;       // latch value read data into a
      logic lat_op;      // latch top operator
      logic exec;        // compute result (start divider if divide)
      logic push_digit;
      logic push_res;
      logic push_sym_op; // push the latched symbol's operator
      logic pop_open;    // drop top operator (the open paren)
      logic rd_bottom;   // read value stack bottom
      logic set_err;
      logic [1:0] err;
      logic clear;       // empty stacks, clear error
   } cmd_type;

   typedef struct packed {
      logic       is_digit;
      logic       is_open;
      logic       is_close;
      logic       is_op;
      logic [1:0] sym_prec;
      logic [1:0] top_prec;
      logic       top_is_open;
      logic       last;
      logic       has_err;
      logic       op_empty;
      logic       op_full;
      logic       val_full;
      logic       val_lt2;
      logic       val_one;
      logic       op_bad;    // latched operator is open paren or not a valid operator
      logic       div_zero;  // latched b is zero
      logic       is_div;    // latched operator is divide
      logic       div_done;
   } sts_type;

endpackage

// ----- hw/rtl/iee_ram.sv -----
module iee_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- hw/rtl/iee_divider.sv -----
module iee_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [iee_pkg::ValueWidth-1:0]     dividend,
   input  logic [iee_pkg::ValueWidth-1:0]     divisor,
   output logic                               done,
   output logic [iee_pkg::ValueWidth-1:0]     quotient
);
   import iee_pkg::*;

   localparam int BitCnt = $clog2(ValueWidth + 1);

   logic [ValueWidth-1:0] q_ff, q_in, d_ff, d_in;
   logic [ValueWidth:0]   r_ff, r_in, trial;
   logic [BitCnt-1:0]     cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, neg_ff, neg_in;
   logic                  na, nb;
   logic [ValueWidth-1:0] ma, mb;

   assign na = dividend[ValueWidth-1];
   assign nb = divisor[ValueWidth-1];
   assign ma = na ? (~dividend + 1'b1) : dividend;
   assign mb = nb ? (~divisor + 1'b1) : divisor;
   assign trial = {r_ff[ValueWidth-1:0], q_ff[ValueWidth-1]} - {1'b0, d_ff};

   // restoring division, one quotient bit per cycle on magnitudes
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff;
      if (start) begin
         q_in = ma; d_in = mb; r_in = '0;
         cnt_in = BitCnt'(ValueWidth); busy_in = 1'b1; neg_in = na ^ nb;
      end else if (busy_ff) begin
         if (trial[ValueWidth]) begin
            r_in = {r_ff[ValueWidth-1:0], q_ff[ValueWidth-1]};
            q_in = {q_ff[ValueWidth-2:0], 1'b0};
         end else begin
            r_in = trial;
            q_in = {q_ff[ValueWidth-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == BitCnt'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign done = !busy_ff;
   assign quotient = neg_ff ? (~q_ff + 1'b1) : q_ff;
endmodule

// ----- hw/rtl/iee_datapath.sv -----
module iee_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  iee_pkg::cmd_type               cmd,
   input  logic [7:0]                     symbol,
   input  logic                           last,
   output iee_pkg::sts_type               sts,
   output logic [31:0]                    res_value,
   output logic [1:0]                     res_status
);
   import iee_pkg::*;

   logic [7:0]            sym_ff;
   logic                  last_ff;
   logic [CntWidth-1:0]   opc_ff, opc_in, valc_ff, valc_in;
   logic [1:0]            err_ff, err_in;
   logic [ValueWidth-1:0] a_ff, b_ff, r_ff, r_in;
   logic [2:0]            op_ff, op_top, op_wdata;
   logic [2:0]            sym_op;
   logic                  op_we, val_we;
   logic [PtrWidth-1:0]   op_waddr, op_raddr, val_waddr, val_raddr;
   logic [ValueWidth-1:0] val_wdata, val_rdata, quo;
   logic                  div_start, div_done;
   logic [2:0]            top_ff;
   logic                  top_vld_ff;
   logic [2:0]            top_op;
   logic                  top_hold_ff;

   iee_ram #(.Width(3), .Depth(StackDepth)) u_op_ram (
      .clock, .wr_en(op_we), .wr_addr(op_waddr), .wr_data(op_wdata),
      .rd_addr(op_raddr), .rd_data(op_top)
   );
   iee_ram #(.Width(ValueWidth), .Depth(StackDepth)) u_val_ram (
      .clock, .wr_en(val_we), .wr_addr(val_waddr), .wr_data(val_wdata),
      .rd_addr(val_raddr), .rd_data(val_rdata)
   );
   iee_divider u_div (
      .clock, .reset, .start(div_start), .dividend(a_ff), .divisor(b_ff),
      .done(div_done), .quotient(quo)
   );

   function automatic logic [1:0] prec(input logic [2:0] op);
      case (op)
         OP_MUL, OP_DIV: prec = 2'd2;
         OP_ADD, OP_SUB: prec = 2'd1;
         default:        prec = 2'd0;
      endcase
   endfunction

   // symbol decode
   always_comb begin
      case (sym_ff)
         CH_ADD:  sym_op = OP_ADD;
         CH_SUB:  sym_op = OP_SUB;
         CH_MUL:  sym_op = OP_MUL;
         CH_DIV:  sym_op = OP_DIV;
         default: sym_op = OP_OPEN;
      endcase
   end

   // top of operator stack is held in a register written on every push; after
   // a pop the top comes from the ram read of the new top
   assign op_raddr  = PtrWidth'(opc_in - 1'b1);
   assign val_raddr = cmd.rd_bottom ? '0 : PtrWidth'(valc_ff - 1'b1);

   // stack pointers and writes
   always_comb begin
      opc_in = opc_ff; valc_in = valc_ff; err_in = err_ff;
      op_we = 1'b0; op_waddr = PtrWidth'(opc_ff); op_wdata = OP_OPEN;
      val_we = 1'b0; val_waddr = PtrWidth'(valc_ff); val_wdata = r_ff;
      if (cmd.rd_op || cmd.pop_open) begin
         opc_in = opc_ff - 1'b1;
      end
      if (cmd.rd_val) begin
         valc_in = valc_ff - 1'b1;
      end
      if (cmd.push_digit) begin
         val_we = 1'b1;
         val_wdata = ValueWidth'(sym_ff - CH_ZERO);
         valc_in = valc_ff + 1'b1;
      end
      if (cmd.push_res) begin
         val_we = 1'b1;
         valc_in = valc_ff + 1'b1;
      end
      if (cmd.push_sym_op) begin
         op_we = 1'b1;
         op_wdata = (sym_ff == CH_OPEN) ? OP_OPEN : sym_op;
         opc_in = opc_ff + 1'b1;
      end
      if (cmd.set_err && err_ff == ST_OK) begin
         err_in = cmd.err;
      end
      if (cmd.set_err || cmd.clear) begin
         opc_in = '0; valc_in = '0;
      end
      if (cmd.clear) begin
         err_in = ST_OK;
      end
   end

   assign div_start = cmd.exec && op_ff == OP_DIV;

   // arithmetic
   always_comb begin
      case (op_ff)
         OP_ADD:  r_in = a_ff + b_ff;
         OP_SUB:  r_in = a_ff - b_ff;
         OP_MUL:  r_in = a_ff * b_ff;
         default: r_in = quo;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opc_ff <= '0; valc_ff <= '0; err_ff <= ST_OK; top_vld_ff <= 1'b0;
      end else begin
         opc_ff <= opc_in; valc_ff <= valc_in; err_ff <= err_in;
         top_vld_ff <= op_we;
      end
      if (cmd.take_item) begin
         sym_ff <= symbol; last_ff <= last;
      end
      if (op_we) begin
         top_ff <= op_wdata;
      end
      if (cmd.lat_op) op_ff <= top_op;
      if (cmd.lat_b) b_ff <= val_rdata;
      if (cmd.lat_a) a_ff <= val_rdata;
      if (cmd.push_res == 1'b0 && (cmd.exec || op_ff == OP_DIV)) r_ff <= r_in;
   end

   // top operator: after a push use the written value, else the ram read
   always_ff @(posedge clock) begin
      if (reset) top_hold_ff <= 1'b0;
      else if (op_we) top_hold_ff <= 1'b1;
      else if (cmd.rd_op || cmd.pop_open) top_hold_ff <= 1'b0;
   end
   assign top_op = top_hold_ff ? top_ff : op_top;

   always_comb begin
      sts.is_digit    = sym_ff >= CH_ZERO && sym_ff <= CH_NINE;
      sts.is_open     = sym_ff == CH_OPEN;
      sts.is_close    = sym_ff == CH_CLOSE;
      sts.is_op       = sym_ff == CH_ADD || sym_ff == CH_SUB ||
                        sym_ff == CH_MUL || sym_ff == CH_DIV;
      sts.sym_prec    = prec(sym_op);
      sts.top_prec    = prec(top_op);
      sts.top_is_open = top_op == OP_OPEN;
      sts.last        = last_ff;
      sts.has_err     = err_ff != ST_OK;
      sts.op_empty    = opc_ff == '0;
      sts.op_full     = opc_ff >= CntWidth'(StackDepth);
      sts.val_full    = valc_ff >= CntWidth'(StackDepth);
      sts.val_lt2     = valc_ff < CntWidth'(2);
      sts.val_one     = valc_ff == CntWidth'(1);
      sts.op_bad      = op_ff == OP_OPEN || op_ff > OP_DIV;
      sts.div_zero    = b_ff == '0;
      sts.is_div      = op_ff == OP_DIV;
      sts.div_done    = div_done && !div_start && !top_vld_ff;
   end

   // bottom of the value stack is read while the result is offered
   assign res_value  = (err_ff == ST_OK) ? val_rdata : 32'd0;
   assign res_status = err_ff;
endmodule

// ----- hw/rtl/iee_control.sv -----
module iee_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  iee_pkg::sts_type sts,
   output iee_pkg::cmd_type cmd
);
   import iee_pkg::*;

   state_type state_ff, state_in;
   logic      close_mode_ff, close_mode_in;
   logic      fin_mode_ff, fin_mode_in;

   // next state
   always_comb begin
      state_in = state_ff;
      close_mode_in = close_mode_ff;
      fin_mode_in = fin_mode_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_DECODE;
         S_DECODE: begin
            close_mode_in = 1'b0; fin_mode_in = 1'b0;
            if (sts.has_err || sts.is_digit || sts.is_open) begin
               state_in = S_FINISH;
            end else if (sts.is_close) begin
               close_mode_in = 1'b1;
               state_in = (!sts.op_empty && !sts.top_is_open) ? S_POP_OP : S_APPLY;
            end else if (sts.is_op) begin
               state_in = (!sts.op_empty && sts.top_prec > sts.sym_prec) ?
                          S_POP_OP : S_APPLY;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_POP_OP: state_in = (sts.val_lt2) ? S_PUSH_R : S_POP_B;
         S_POP_B:  state_in = S_POP_A;
         S_POP_A:  state_in = S_EXEC;
         S_EXEC:   state_in = (sts.op_bad || (sts.is_div && sts.div_zero)) ? S_PUSH_R :
                              (sts.is_div ? S_DIV_RUN : S_PUSH_R);
         S_DIV_RUN: if (sts.div_done) state_in = S_PUSH_R;
         S_PUSH_R: begin
            // loop test after the push settles
            if (sts.has_err) state_in = S_FINISH;
            else if (fin_mode_ff) state_in = sts.op_empty ? S_FINISH : S_POP_OP;
            else if (close_mode_ff)
               state_in = (!sts.op_empty && !sts.top_is_open) ? S_POP_OP : S_APPLY;
            else
               state_in = (!sts.op_empty && sts.top_prec > sts.sym_prec) ?
                          S_POP_OP : S_APPLY;
         end
         S_APPLY: state_in = S_FINISH;
         S_FINISH: begin
            if (!sts.has_err && sts.last && !fin_mode_ff && !sts.op_empty) begin
               fin_mode_in = 1'b1;
               state_in = S_POP_OP;
            end else if (sts.last) begin
               state_in = S_READ_RES;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_READ_RES: state_in = S_OUTPUT;
         S_OUTPUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.take_item = req_tvalid;
         end
         S_DECODE: begin
            if (!sts.has_err) begin
               if (sts.is_digit) begin
                  if (sts.val_full) begin cmd.set_err = 1'b1; cmd.err = ST_MALFORM; end
                  else cmd.push_digit = 1'b1;
               end else if (sts.is_open) begin
                  if (sts.op_full) begin cmd.set_err = 1'b1; cmd.err = ST_MALFORM; end
                  else cmd.push_sym_op = 1'b1;
               end else if (!sts.is_close && !sts.is_op) begin
                  cmd.set_err = 1'b1; cmd.err = ST_SYMBOL;
               end
            end
         end
         S_POP_OP: begin
            if (sts.val_lt2) begin cmd.set_err = 1'b1; cmd.err = ST_MALFORM; end
            else begin cmd.rd_op = 1'b1; cmd.rd_val = 1'b1; cmd.lat_op = 1'b1; end
         end
         S_POP_B: begin
            cmd.lat_b = 1'b1; cmd.rd_val = 1'b1;
         end
         S_POP_A: cmd.lat_a = 1'b1;
         S_EXEC: begin
            if (sts.op_bad) begin cmd.set_err = 1'b1; cmd.err = ST_MALFORM; end
            else if (sts.is_div && sts.div_zero) begin
               cmd.set_err = 1'b1; cmd.err = ST_DIV0;
            end else cmd.exec = 1'b1;
         end
         S_PUSH_R: begin
            if (!sts.has_err) cmd.push_res = 1'b1;
         end
         // close paren drops its open paren, an operator is pushed
         S_APPLY: begin
            if (!sts.has_err) begin
               if (sts.is_close) begin
                  if (sts.op_empty) begin cmd.set_err = 1'b1; cmd.err = ST_MALFORM; end
                  else cmd.pop_open = 1'b1;
               end else begin
                  if (sts.op_full) begin cmd.set_err = 1'b1; cmd.err = ST_MALFORM; end
                  else cmd.push_sym_op = 1'b1;
               end
            end
         end
         S_READ_RES: begin
            cmd.rd_bottom = 1'b1;
            if (!sts.has_err && !sts.val_one) begin
               cmd.set_err = 1'b1; cmd.err = ST_MALFORM;
            end
         end
         S_OUTPUT: begin
            cmd.rd_bottom = 1'b1;
            rsp_tvalid = 1'b1;
            cmd.clear = rsp_tready;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; close_mode_ff <= 1'b0; fin_mode_ff <= 1'b0;
      end else begin
         state_ff <= state_in; close_mode_ff <= close_mode_in;
         fin_mode_ff <= fin_mode_in;
      end
   end
endmodule

// ----- hw/rtl/infix_expression_evaluator_top.sv -----
// Infix expression evaluator: takes one ASCII character per item (single digits,
// + - * /, parentheses) and on the item with tlast returns the signed 32-bit value
// and a status (0 ok, 1 divide by zero, 2 unknown symbol, 3 malformed or stack
// overflow; value 0 on any error). A divide runs the one-bit-per-cycle divider.
// The last item first runs any reductions that remain, then waits for rsp_tready.
// The stacks are 16-entry RAMs with a registered read port, which sets the length
// of the reduction sequence. Items are processed one at a time.
module infix_expression_evaluator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // symbol[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // value[31:0], status[33:32], zero pad
);
   import iee_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [31:0] res_value;
   logic [1:0]  res_status;

   iee_control u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .cmd
   );

   iee_datapath u_dp (
      .clock, .reset, .cmd, .symbol(req_tdata), .last(req_tlast), .sts,
      .res_value, .res_status
   );

   assign rsp_tdata = {6'd0, res_status, res_value};
endmodule
